// File: src/wss_pkg.sv
`timescale 1ns / 1ps

package wss_pkg;

  localparam int NUM_SCHEDULES = 5;
  localparam int SLOTS_PER_DAY = 4;
  localparam int DAYS          = 7;
  localparam int TABLE_DEPTH   = NUM_SCHEDULES * DAYS * SLOTS_PER_DAY;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);

  localparam int SCHED_W = 3;
  localparam int DAY_W   = 3;
  localparam int SLOT_W  = 2;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int DEG_W   = 8;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;

  localparam logic [7:0]         CLEARED_HOUR   = 8'hFF;
  localparam logic [SCHED_W-1:0] RESET_SCHEDULE = 3'd4;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_RESYNC = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef struct packed {
    logic [7:0]       hour;
    logic [MIN_W-1:0] minute;
    logic [DEG_W-1:0] heat;
    logic [DEG_W-1:0] cool;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic step;
    logic mem_rd_in;
    logic mem_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    issue_last;
  } status_t;

  // Factory day: wake, leave, return, sleep.
  function automatic entry_t default_entry(input logic [SLOT_W-1:0] k);
    entry_t e;
    e.hour   = CLEARED_HOUR;
    e.minute = '0;
    e.heat   = '0;
    e.cool   = '0;
    case (k)
      2'd0: begin
        e.hour = 8'd4;  e.minute = 6'd0;  e.heat = 8'd68; e.cool = 8'd78;
      end
      2'd1: begin
        e.hour = 8'd8;  e.minute = 6'd30; e.heat = 8'd65; e.cool = 8'd82;
      end
      2'd2: begin
        e.hour = 8'd16; e.minute = 6'd30; e.heat = 8'd68; e.cool = 8'd78;
      end
      2'd3: begin
        e.hour = 8'd22; e.minute = 6'd0;  e.heat = 8'd65; e.cool = 8'd76;
      end
      default: begin
        e.hour = CLEARED_HOUR;
      end
    endcase
    return e;
  endfunction

endpackage

// File: src/weekly_setpoint_scheduler.sv
`timescale 1ns / 1ps
// States per item: idle, then write, read or scan and drain, then finish and out.
// The scan reads one table entry per cycle from a single-port table memory
// (4 entries for a tick, 28 for a resync), followed by the drain and finish states.
// One item at a time: the next beat is taken the cycle after the result beat leaves.
// Reset (rst, synchronous) restores the factory day in every schedule at once,
// zero setpoints, no trip record and schedule 4; no clearing pass is needed.

module weekly_setpoint_scheduler import wss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [SCHED_W-1:0]    cfg_data,       // active_schedule
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // day, hour, minute, sched_index, slot, entry_hour, entry_minute,
  // entry_heat, entry_cool, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [IN_USER_W-1:0]  s_axis_tuser,   // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // heat_setpoint, cool_setpoint, setpoint_changed, controlling_schedule,
  // trip_valid, trip_day, trip_slot, read_hour, read_minute, read_heat, read_cool
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  wss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (action_t'(s_axis_tuser)),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wss_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .cmd      (cmd),
    .status   (status),
    .out_data (m_axis_tdata)
  );

endmodule

// File: src/wss_ctrl.sv
`timescale 1ns / 1ps

module wss_ctrl import wss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  action_t in_action,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_WRITE  = 7'b0000010,
    S_READ   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (in_action)
            ACT_TICK, ACT_RESYNC: state_next = S_SCAN;
            ACT_WRITE:            state_next = S_WRITE;
            ACT_READ:             state_next = S_READ;
          endcase
        end
      end
      S_WRITE: begin
        cmd.mem_wr = 1'b1;
        state_next = S_FINISH;
      end
      S_READ: begin
        cmd.mem_rd_in = 1'b1;
        state_next    = S_FINISH;
      end
      S_SCAN: begin
        // issue one entry per cycle; the previous one is evaluated alongside
        cmd.scan_rd = 1'b1;
        cmd.step    = 1'b1;
        if (status.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  a_finish_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result not presented after finish");

  a_write_action: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> status.action == ACT_WRITE)
    else $error("table write outside a write item");

  a_read_action: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_rd_in |-> status.action == ACT_READ)
    else $error("addressed read outside a read item");

endmodule

// File: src/wss_dpath.sv
`timescale 1ns / 1ps

module wss_dpath import wss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [SCHED_W-1:0]    cfg_data,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [IN_USER_W-1:0]  in_user,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_DAY - 1);
  localparam logic [DAY_W-1:0]  LAST_DAY  = DAY_W'(DAYS - 1);

  // captured item
  action_t             in_action;
  logic [DAY_W-1:0]    in_day;
  logic [HOUR_W-1:0]   in_hour;
  logic [MIN_W-1:0]    in_minute;
  logic [SCHED_W-1:0]  in_sched;
  logic [SLOT_W-1:0]   in_slot;
  entry_t              in_entry;

  // held state
  logic [SCHED_W-1:0]  active;
  logic [DEG_W-1:0]    held_heat;
  logic [DEG_W-1:0]    held_cool;
  logic [SCHED_W-1:0]  setter;
  logic                trip_flag;
  logic [DAY_W-1:0]    trip_day;
  logic [SLOT_W-1:0]   trip_slot;
  logic                changed;
  entry_t              read_q;

  // scan walker and table
  logic [DAY_W-1:0]    scan_day;
  logic [SLOT_W-1:0]   scan_slot;
  logic [SCHED_W-1:0]  a_sched;
  logic [DAY_W-1:0]    a_day;
  logic [SLOT_W-1:0]   a_slot;
  logic                a_in_range;
  logic [ADDR_W-1:0]   a_addr;
  logic                rd_en;

  entry_t              mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] written;
  entry_t              rd_q;
  logic                rd_written;
  logic                rd_in_range;
  logic [SLOT_W-1:0]   rd_slot;
  entry_t              ent;

  // evaluation stage
  logic                ev_valid;
  logic [DAY_W-1:0]    ev_day;
  logic [SLOT_W-1:0]   ev_slot;
  logic                skip;
  logic                tick_match;
  logic                later;

  // accumulators
  logic                hit;
  logic [DAY_W-1:0]    hit_day;
  logic [SLOT_W-1:0]   hit_slot;
  logic [DEG_W-1:0]    hit_heat;
  logic [DEG_W-1:0]    hit_cool;
  logic                any;
  logic                found;
  logic                prev_ok;
  logic [DAY_W-1:0]    last_day;
  logic [SLOT_W-1:0]   last_slot;
  logic [DEG_W-1:0]    last_heat;
  logic [DEG_W-1:0]    last_cool;
  logic [DAY_W-1:0]    pick_day;
  logic [SLOT_W-1:0]   pick_slot;
  logic [DEG_W-1:0]    pick_heat;
  logic [DEG_W-1:0]    pick_cool;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_action       <= action_t'(in_user[1:0]);
      in_day          <= in_data[2:0];
      in_hour         <= in_data[7:3];
      in_minute       <= in_data[13:8];
      in_sched        <= in_data[16:14];
      in_slot         <= in_data[18:17];
      in_entry.hour   <= in_data[26:19];
      in_entry.minute <= in_data[32:27];
      in_entry.heat   <= in_data[40:33];
      in_entry.cool   <= in_data[48:41];
    end
  end

  // walker: a tick visits today's slots, a resync the whole week
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scan_day  <= (action_t'(in_user[1:0]) == ACT_TICK) ? in_data[2:0] : '0;
      scan_slot <= '0;
    end else if (cmd.step) begin
      if (scan_slot == LAST_SLOT) begin
        scan_slot <= '0;
        scan_day  <= scan_day + 1'b1;
      end else begin
        scan_slot <= scan_slot + 1'b1;
      end
    end
  end

  assign status.action     = in_action;
  assign status.issue_last = (scan_slot == LAST_SLOT) &&
                             ((in_action == ACT_TICK) || (scan_day == LAST_DAY));

  always_comb begin
    if (cmd.scan_rd) begin
      a_sched = active;
      a_day   = scan_day;
      a_slot  = scan_slot;
    end else begin
      a_sched = in_sched;
      a_day   = in_day;
      a_slot  = in_slot;
    end
    a_in_range = ({1'b0, a_sched} < (SCHED_W + 1)'(NUM_SCHEDULES)) &&
                 (a_day < DAY_W'(DAYS)) &&
                 ({1'b0, a_slot} < (SLOT_W + 1)'(SLOTS_PER_DAY));
    a_addr = a_in_range ?
             (ADDR_W'(a_sched) * ADDR_W'(DAYS) + ADDR_W'(a_day)) * ADDR_W'(SLOTS_PER_DAY)
             + ADDR_W'(a_slot) : '0;
  end

  assign rd_en = cmd.scan_rd | cmd.mem_rd_in;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && a_in_range) begin
      mem[a_addr] <= in_entry;
    end
    if (rd_en) begin
      rd_q <= mem[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written     <= '0;
      rd_written  <= 1'b0;
      rd_in_range <= 1'b0;
      rd_slot     <= '0;
      ev_valid    <= 1'b0;
      ev_day      <= '0;
      ev_slot     <= '0;
    end else begin
      if (cmd.mem_wr && a_in_range) begin
        written[a_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written  <= written[a_addr];
        rd_in_range <= a_in_range;
        rd_slot     <= a_slot;
      end
      ev_valid <= cmd.scan_rd;
      ev_day   <= scan_day;
      ev_slot  <= scan_slot;
    end
  end

  // never-written entries read as the factory day, out-of-range ones as cleared
  always_comb begin
    if (!rd_in_range) begin
      ent.hour   = CLEARED_HOUR;
      ent.minute = '0;
      ent.heat   = '0;
      ent.cool   = '0;
    end else if (rd_written) begin
      ent = rd_q;
    end else begin
      ent = default_entry(rd_slot);
    end
  end

  always_comb begin
    skip       = trip_flag && (trip_day == ev_day) && (trip_slot == ev_slot);
    tick_match = !skip && (ent.hour == {3'b000, in_hour}) && (ent.minute == in_minute);
    later      = (in_day < ev_day) ||
                 ((in_day == ev_day) &&
                  (({3'b000, in_hour} < ent.hour) ||
                   (({3'b000, in_hour} == ent.hour) && (in_minute < ent.minute))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit     <= 1'b0;
      any     <= 1'b0;
      found   <= 1'b0;
      prev_ok <= 1'b0;
    end else if (cmd.capture) begin
      hit     <= 1'b0;
      any     <= 1'b0;
      found   <= 1'b0;
      prev_ok <= 1'b0;
    end else if (ev_valid) begin
      if (in_action == ACT_TICK) begin
        if (!hit && tick_match) begin
          hit <= 1'b1;
        end
      end else if (ent.hour != CLEARED_HOUR) begin
        if (!found && later) begin
          found <= 1'b1;
          if (any) begin
            prev_ok <= 1'b1;
          end
        end
        any <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid) begin
      if (in_action == ACT_TICK) begin
        if (!hit && tick_match) begin
          hit_day  <= ev_day;
          hit_slot <= ev_slot;
          hit_heat <= ent.heat;
          hit_cool <= ent.cool;
        end
      end else if (ent.hour != CLEARED_HOUR) begin
        if (!found && later && any) begin
          pick_day  <= last_day;
          pick_slot <= last_slot;
          pick_heat <= last_heat;
          pick_cool <= last_cool;
        end
        last_day  <= ev_day;
        last_slot <= ev_slot;
        last_heat <= ent.heat;
        last_cool <= ent.cool;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= RESET_SCHEDULE;
      held_heat <= '0;
      held_cool <= '0;
      setter    <= RESET_SCHEDULE;
      trip_flag <= 1'b0;
      trip_day  <= '0;
      trip_slot <= '0;
      changed   <= 1'b0;
      read_q    <= '0;
    end else begin
      if (cfg_we) begin
        active <= cfg_data;
      end
      if (cmd.finish) begin
        unique case (in_action)
          ACT_TICK: begin
            changed <= hit;
            read_q  <= '0;
            if (hit) begin
              held_heat <= hit_heat;
              held_cool <= hit_cool;
              setter    <= active;
              trip_flag <= 1'b1;
              trip_day  <= hit_day;
              trip_slot <= hit_slot;
            end
          end
          ACT_RESYNC: begin
            setter  <= active;
            changed <= any;
            read_q  <= '0;
            if (!any) begin
              trip_flag <= 1'b0;
              trip_day  <= '0;
              trip_slot <= '0;
            end else begin
              // wrap to the week's last entry when nothing earlier qualifies
              trip_flag <= 1'b1;
              held_heat <= prev_ok ? pick_heat : last_heat;
              held_cool <= prev_ok ? pick_cool : last_cool;
              trip_day  <= prev_ok ? pick_day  : last_day;
              trip_slot <= prev_ok ? pick_slot : last_slot;
            end
          end
          ACT_READ: begin
            changed <= 1'b0;
            read_q  <= ent;
          end
          ACT_WRITE: begin
            changed <= 1'b0;
            read_q  <= '0;
          end
        endcase
      end
    end
  end

  assign out_data = {read_q.cool, read_q.heat, read_q.minute, read_q.hour,
                     trip_slot, trip_day, trip_flag, setter, changed,
                     held_cool, held_heat};

  a_trip_clear: assert property (@(posedge clk) disable iff (rst)
    ($fell(trip_flag) && !$past(rst)) |->
      ($past(cmd.finish) && $past(in_action) == ACT_RESYNC))
    else $error("trip record dropped outside an empty resync");

  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.finish)) |->
      ($stable(held_heat) && $stable(held_cool) && $stable(setter)))
    else $error("setpoints moved outside finish");

endmodule

// File: dv/tb_weekly_setpoint_scheduler.sv
`timescale 1ns / 1ps

module tb_weekly_setpoint_scheduler;
  import wss_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 66;

  // Request fields from the highest bit down, padded to whole bytes.
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] entry_cool;
    logic [7:0] entry_heat;
    logic [5:0] entry_minute;
    logic [7:0] entry_hour;
    logic [1:0] slot;
    logic [2:0] sched_index;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] day;
  } req_fields_t;

  typedef struct packed {
    action_t     act;
    req_fields_t f;
  } sched_req_t;

  // Result fields from the highest bit down.
  typedef struct packed {
    logic [7:0] read_cool;
    logic [7:0] read_heat;
    logic [5:0] read_minute;
    logic [7:0] read_hour;
    logic [1:0] trip_slot;
    logic [2:0] trip_day;
    logic       trip_valid;
    logic [2:0] controlling_schedule;
    logic       setpoint_changed;
    logic [7:0] cool_setpoint;
    logic [7:0] heat_setpoint;
  } setpoint_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [SCHED_W-1:0]    cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // day, hour, minute, sched_index, slot,
                                              // entry_hour, entry_minute, entry_heat,
                                              // entry_cool, zero fill
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;  // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // heat_setpoint, cool_setpoint,
                                              // setpoint_changed, controlling_schedule,
                                              // trip_valid, trip_day, trip_slot, read_hour,
                                              // read_minute, read_heat, read_cool

  weekly_setpoint_scheduler DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted block state.
  entry_t       plan_table [NUM_SCHEDULES][DAYS][SLOTS_PER_DAY];
  logic [7:0]   pred_heat;
  logic [7:0]   pred_cool;
  logic [2:0]   pred_owner;
  logic         pred_trip_on;
  logic [2:0]   pred_trip_day;
  logic [1:0]   pred_trip_slot;
  logic [2:0]   pred_active;

  sched_req_t     req_q [$];
  setpoint_beat_t pending_setpoints [$];
  sched_req_t     cur_req;
  int             reqs_in_flight = 0;
  int             errors = 0;
  int             cycles = 0;
  int             n_by_action [4] = '{0, 0, 0, 0};
  int             n_loads = 0;
  int             n_checked = 0;
  int             n_settings = 0;
  logic           in_fire = 1'b0;
  logic           out_fire = 1'b0;
  logic           tx_idle_on = 1'b1;
  logic           rx_idle_on = 1'b1;
  int             tx_gap = 0;
  int             rx_stall = 0;

  function automatic entry_t lookup(logic [2:0] s, logic [2:0] d, logic [1:0] k);
    entry_t e;
    e = '{CLEARED_HOUR, 6'd0, 8'd0, 8'd0};
    if (s < NUM_SCHEDULES && d < DAYS) e = plan_table[s][d][k];
    return e;
  endfunction

  function automatic logic tick_match(logic [2:0] d, logic [4:0] h, logic [5:0] m);
    entry_t e;
    logic   hit;
    hit = 1'b0;
    for (int k = 0; k < SLOTS_PER_DAY; k++) begin
      e = lookup(pred_active, d, 2'(k));
      // skip the slot that tripped last
      if (!hit && !(pred_trip_on && pred_trip_day == d && pred_trip_slot == 2'(k)) &&
          e.hour == {3'b000, h} && e.minute == m) begin
        hit            = 1'b1;
        pred_trip_on   = 1'b1;
        pred_trip_day  = d;
        pred_trip_slot = 2'(k);
        pred_heat      = e.heat;
        pred_cool      = e.cool;
        pred_owner     = pred_active;
      end
    end
    return hit;
  endfunction

  function automatic logic resync_scan(logic [2:0] now_d, logic [4:0] now_h,
                                       logic [5:0] now_m);
    entry_t     e;
    logic       any, found, prev_ok;
    logic [2:0] last_d, pick_d;
    logic [1:0] last_k, pick_k;
    any = 1'b0; found = 1'b0; prev_ok = 1'b0;
    last_d = '0; last_k = '0; pick_d = '0; pick_k = '0;
    pred_owner = pred_active;
    for (int d = 0; d < DAYS; d++) begin
      for (int k = 0; k < SLOTS_PER_DAY; k++) begin
        e = lookup(pred_active, 3'(d), 2'(k));
        if (e.hour != CLEARED_HOUR) begin
          if (!found) begin
            if (now_d < 3'(d)) found = 1'b1;
            else if (now_d == 3'(d)) begin
              if ({3'b000, now_h} < e.hour) found = 1'b1;
              else if ({3'b000, now_h} == e.hour && now_m < e.minute) found = 1'b1;
            end
            if (found && any) begin
              prev_ok = 1'b1;
              pick_d  = last_d;
              pick_k  = last_k;
            end
          end
          any    = 1'b1;
          last_d = 3'(d);
          last_k = 2'(k);
        end
      end
    end
    if (!any) begin
      pred_trip_on   = 1'b0;
      pred_trip_day  = '0;
      pred_trip_slot = '0;
      return 1'b0;
    end
    // wrap to the last entry of the week
    if (!prev_ok) begin
      pick_d = last_d;
      pick_k = last_k;
    end
    e = lookup(pred_active, pick_d, pick_k);
    pred_heat      = e.heat;
    pred_cool      = e.cool;
    pred_trip_on   = 1'b1;
    pred_trip_day  = pick_d;
    pred_trip_slot = pick_k;
    return 1'b1;
  endfunction

  function automatic setpoint_beat_t predict_setpoints(sched_req_t r);
    setpoint_beat_t b;
    entry_t         e;
    logic           hit;
    b   = '0;
    hit = 1'b0;
    case (r.act)
      ACT_TICK: begin
        hit = tick_match(r.f.day, r.f.hour, r.f.minute);
      end
      ACT_WRITE: begin
        if (r.f.sched_index < NUM_SCHEDULES && r.f.day < DAYS)
          plan_table[r.f.sched_index][r.f.day][r.f.slot] =
            '{r.f.entry_hour, r.f.entry_minute, r.f.entry_heat, r.f.entry_cool};
      end
      ACT_RESYNC: begin
        hit = resync_scan(r.f.day, r.f.hour, r.f.minute);
      end
      default: begin
        e = lookup(r.f.sched_index, r.f.day, r.f.slot);
        b.read_hour   = e.hour;
        b.read_minute = e.minute;
        b.read_heat   = e.heat;
        b.read_cool   = e.cool;
      end
    endcase
    b.heat_setpoint        = pred_heat;
    b.cool_setpoint        = pred_cool;
    b.setpoint_changed     = hit;
    b.controlling_schedule = pred_owner;
    b.trip_valid           = pred_trip_on;
    b.trip_day             = pred_trip_day;
    b.trip_slot            = pred_trip_slot;
    return b;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result checking and request prediction share one process so pushes and
  // pops of the expected-result queue never race.
  always @(posedge clk) begin
    setpoint_beat_t got, want;
    in_fire  <= !rst && s_axis_tvalid && s_axis_tready;
    out_fire <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_setpoints.size() == 0) begin
        $error("result beat with no expected result waiting");
        errors++;
      end else begin
        want = pending_setpoints.pop_front();
        n_checked++;
        check_field("heat_setpoint", 32'(want.heat_setpoint), 32'(got.heat_setpoint));
        check_field("cool_setpoint", 32'(want.cool_setpoint), 32'(got.cool_setpoint));
        check_field("setpoint_changed", 32'(want.setpoint_changed),
                    32'(got.setpoint_changed));
        check_field("controlling_schedule", 32'(want.controlling_schedule),
                    32'(got.controlling_schedule));
        check_field("trip_valid", 32'(want.trip_valid), 32'(got.trip_valid));
        check_field("trip_day", 32'(want.trip_day), 32'(got.trip_day));
        check_field("trip_slot", 32'(want.trip_slot), 32'(got.trip_slot));
        check_field("read_hour", 32'(want.read_hour), 32'(got.read_hour));
        check_field("read_minute", 32'(want.read_minute), 32'(got.read_minute));
        check_field("read_heat", 32'(want.read_heat), 32'(got.read_heat));
        check_field("read_cool", 32'(want.read_cool), 32'(got.read_cool));
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      want = predict_setpoints(cur_req);
      if (want.setpoint_changed) n_loads++;
      n_by_action[cur_req.act]++;
      pending_setpoints.push_back(want);
      reqs_in_flight--;
    end
  end

  // Request driver: hold the beat until taken, then draw the gap before the next.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire || !s_axis_tvalid) begin
        if (in_fire) tx_gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          s_axis_tdata  <= cur_req.f;
          s_axis_tuser  <= cur_req.act;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink: after each beat, hold ready low for a randomly drawn stall (none when rx_idle_on is off).
  always @(negedge clk) begin
    if (out_fire) rx_stall = rx_idle_on ? $urandom_range(0, 6) : 0;
    if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic sched_req_t req_of(action_t act, int d, int h, int m, int s, int k,
                                        int eh, int em, int eheat, int ecool);
    sched_req_t r;
    r = '0;
    r.act            = act;
    r.f.day          = 3'(d);
    r.f.hour         = 5'(h);
    r.f.minute       = 6'(m);
    r.f.sched_index  = 3'(s);
    r.f.slot         = 2'(k);
    r.f.entry_hour   = 8'(eh);
    r.f.entry_minute = 6'(em);
    r.f.entry_heat   = 8'(eheat);
    r.f.entry_cool   = 8'(ecool);
    return r;
  endfunction

  function automatic sched_req_t random_req();
    sched_req_t r;
    entry_t     e;
    int         pick, sub;
    r.f   = IN_DATA_W'({$urandom, $urandom});
    r.f.pad = '0;
    pick  = $urandom_range(0, 99);
    sub   = $urandom_range(0, 9);
    if (pick < 35) begin
      // tick, mostly on a time that the active schedule holds
      r.act    = ACT_TICK;
      r.f.day  = 3'($urandom_range(0, 6));
      e = lookup(pred_active, r.f.day, 2'($urandom_range(0, 3)));
      if (e.hour < 32 && sub != 0) begin
        r.f.hour   = e.hour[4:0];
        r.f.minute = e.minute;
      end else begin
        r.f.hour   = 5'($urandom_range(0, 23));
        r.f.minute = 6'($urandom_range(0, 59));
      end
    end else if (pick < 45) begin
      r.act = ACT_TICK;
      r.f.day = 3'($urandom_range(0, 7));
    end else if (pick < 70) begin
      r.act = ACT_WRITE;
      if (sub != 0) r.f.sched_index = 3'($urandom_range(0, NUM_SCHEDULES - 1));
      if ($urandom_range(0, 11) != 0) r.f.day = 3'($urandom_range(0, 6));
      if (sub < 6) r.f.entry_hour = 8'($urandom_range(0, 23));
      else if (sub < 8) r.f.entry_hour = CLEARED_HOUR;
      if ($urandom_range(0, 7) != 0) r.f.entry_minute = 6'($urandom_range(0, 59));
    end else if (pick < 82) begin
      r.act = ACT_RESYNC;
      if (sub != 0) begin
        r.f.day    = 3'($urandom_range(0, 6));
        r.f.hour   = 5'($urandom_range(0, 23));
        r.f.minute = 6'($urandom_range(0, 59));
      end
    end else begin
      r.act = ACT_READ;
      if (sub < 8) begin
        r.f.sched_index = 3'($urandom_range(0, NUM_SCHEDULES - 1));
        r.f.day         = 3'($urandom_range(0, 6));
      end
    end
    return r;
  endfunction

  task automatic push_req(sched_req_t r);
    req_q.push_back(r);
    reqs_in_flight++;
  endtask

  // Hold off until every request is taken and every result is back.
  task automatic drain_and_settle();
    while (reqs_in_flight > 0 || pending_setpoints.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_active(logic [2:0] v);
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_data    <= v;
    pred_active  = v;
    n_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [2:0] phase_cfg [9];
    phase_cfg = '{3'd4, 3'd7, 3'd0, 3'd1, 3'd3, 3'd5, 3'd2, 3'd6, 3'd4};

    for (int s = 0; s < NUM_SCHEDULES; s++) begin
      for (int d = 0; d < DAYS; d++) begin
        plan_table[s][d][0] = '{8'd4,  6'd0,  8'd68, 8'd78};
        plan_table[s][d][1] = '{8'd8,  6'd30, 8'd65, 8'd82};
        plan_table[s][d][2] = '{8'd16, 6'd30, 8'd68, 8'd78};
        plan_table[s][d][3] = '{8'd22, 6'd0,  8'd65, 8'd76};
      end
    end
    pred_heat = '0; pred_cool = '0; pred_owner = 3'd4;
    pred_trip_on = 1'b0; pred_trip_day = '0; pred_trip_slot = '0;
    pred_active = RESET_SCHEDULE;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pass on the reset schedule.
    push_req(req_of(ACT_READ,   0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_READ,   7, 0, 0, 7, 3, 0, 0, 0, 0));
    push_req(req_of(ACT_TICK,   0, 4, 0, 0, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_TICK,   0, 4, 0, 0, 0, 0, 0, 0, 0));  // tripped slot skipped
    push_req(req_of(ACT_TICK,   0, 8, 30, 0, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_TICK,   7, 4, 0, 0, 0, 0, 0, 0, 0));  // day 7 matches nothing
    push_req(req_of(ACT_RESYNC, 3, 12, 0, 0, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_RESYNC, 0, 0, 0, 0, 0, 0, 0, 0, 0));  // wraps to week end
    push_req(req_of(ACT_RESYNC, 7, 31, 63, 0, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_RESYNC, 6, 23, 59, 0, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_WRITE,  2, 0, 0, 4, 1, 255, 0, 0, 0));
    push_req(req_of(ACT_WRITE,  0, 0, 0, 5, 0, 1, 2, 3, 4));  // out of range, dropped
    push_req(req_of(ACT_WRITE,  7, 0, 0, 0, 0, 1, 2, 3, 4));
    push_req(req_of(ACT_READ,   2, 0, 0, 4, 1, 0, 0, 0, 0));
    push_req(req_of(ACT_READ,   0, 0, 0, 5, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_WRITE,  1, 0, 0, 4, 2, 31, 63, 255, 0));
    push_req(req_of(ACT_TICK,   1, 31, 63, 0, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_WRITE,  0, 0, 0, 4, 0, 0, 0, 0, 255));
    push_req(req_of(ACT_TICK,   0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_RESYNC, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_WRITE,  5, 0, 0, 4, 0, 10, 10, 1, 2));
    push_req(req_of(ACT_WRITE,  5, 0, 0, 4, 1, 10, 10, 3, 4));
    repeat (3) push_req(req_of(ACT_TICK, 5, 10, 10, 0, 0, 0, 0, 0, 0));
    push_req(req_of(ACT_READ,   1, 0, 0, 4, 2, 0, 0, 0, 0));
    drain_and_settle();

    for (int p = 0; p < 9; p++) begin
      set_active(phase_cfg[p]);
      tx_idle_on = (p == 2) ? 1'b0 : 1'(($urandom_range(0, 3)) != 0);
      rx_idle_on = (p == 2) ? 1'b0 : 1'(($urandom_range(0, 3)) != 0);
      if (phase_cfg[p] == 3'd3 || phase_cfg[p] == 3'd7) begin
        // empty schedule on resync, then a tick that cannot match
        push_req(req_of(ACT_RESYNC, 3, 12, 0, 0, 0, 0, 0, 0, 0));
        push_req(req_of(ACT_TICK,   0, 4, 0, 0, 0, 0, 0, 0, 0));
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) push_req(random_req());
      if (phase_cfg[p] == 3'd1) begin
        // clear the whole week of schedule 3 before it goes active
        for (int d = 0; d < DAYS; d++)
          for (int k = 0; k < SLOTS_PER_DAY; k++)
            push_req(req_of(ACT_WRITE, d, 0, 0, 3, k, 255, 0, 0, 0));
      end
      drain_and_settle();
    end

    $display("Ran %0d ticks, %0d writes, %0d resyncs, %0d reads over %0d schedule settings",
             n_by_action[ACT_TICK], n_by_action[ACT_WRITE], n_by_action[ACT_RESYNC],
             n_by_action[ACT_READ], n_settings);
    $display("Checked %0d result beats, %0d of them loaded setpoints", n_checked, n_loads);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
